/* sv/pbse_pkg.sv */
package pbse_pkg;

  // Token kinds as they arrive on in_tuser.
  typedef enum logic [3:0] {
    FN_FALSE  = 4'd0,
    FN_TRUE   = 4'd1,
    FN_NONDET = 4'd2,
    FN_NOT    = 4'd3,
    FN_AND    = 4'd4,
    FN_OR     = 4'd5,
    FN_XOR    = 4'd6,
    FN_EQ     = 4'd7,
    FN_NEQ    = 4'd8,
    FN_PAREN  = 4'd9,
    FN_VAR    = 4'd10
  } func_t;

  typedef enum logic [1:0] {
    BANK_SHARED_NOW  = 2'd0,
    BANK_LOCAL_NOW   = 2'd1,
    BANK_SHARED_NEXT = 2'd2,
    BANK_LOCAL_NEXT  = 2'd3
  } bank_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONDET = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_t;

  // Configuration register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SHARED_NOW  = 2'd0,
    REG_LOCAL_NOW   = 2'd1,
    REG_SHARED_NEXT = 2'd2,
    REG_LOCAL_NEXT  = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_PUSH,
    OP_NOT,
    OP_BIN
  } op_kind_t;

  typedef enum logic [2:0] {
    BIN_AND,
    BIN_OR,
    BIN_XOR,
    BIN_EQ,
    BIN_NEQ
  } bin_t;

  // A classified token as it travels from the front end to the stack unit.
  typedef struct packed {
    op_kind_t kind;
    bin_t     bin;
    logic     bit_val;
    logic     nondet;
    logic     last;
  } op_t;

  localparam int VAR_BITS = 16;

  typedef struct packed {
    logic [VAR_BITS-1:0] shared_now;
    logic [VAR_BITS-1:0] local_now;
    logic [VAR_BITS-1:0] shared_next;
    logic [VAR_BITS-1:0] local_next;
  } vars_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q_status_t;

endpackage

/* sv/pbse_front.sv */
module pbse_front #(
  parameter int SHARED_VARS = 16,
  parameter int LOCAL_VARS  = 16
) (
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // var_bank[1:0], var_index[5:2], zero pad
  input  logic [3:0]     in_tuser,   // func[3:0]
  input  logic           in_tlast,
  input  pbse_pkg::vars_t    vars,
  input  pbse_pkg::q_status_t q_st,
  output logic           q_push,
  output pbse_pkg::op_t  q_op
);
  import pbse_pkg::*;

  func_t               func;
  bank_t               bank;
  logic [3:0]          idx;
  logic [VAR_BITS-1:0] vec;
  logic                in_range;
  logic                var_bit;

  assign func = func_t'(in_tuser);
  assign bank = bank_t'(in_tdata[1:0]);
  assign idx  = in_tdata[5:2];

  assign in_tready = !q_st.full;
  assign q_push    = in_tvalid && in_tready;

  // Variable lookup is done here so that the stack unit only sees push values.
  always_comb begin
    unique case (bank)
      BANK_SHARED_NOW: begin
        vec      = vars.shared_now;
        in_range = int'(idx) < SHARED_VARS;
      end
      BANK_LOCAL_NOW: begin
        vec      = vars.local_now;
        in_range = int'(idx) < LOCAL_VARS;
      end
      BANK_SHARED_NEXT: begin
        vec      = vars.shared_next;
        in_range = int'(idx) < SHARED_VARS;
      end
      default: begin
        vec      = vars.local_next;
        in_range = int'(idx) < LOCAL_VARS;
      end
    endcase
  end

  assign var_bit = in_range && vec[idx];

  always_comb begin
    q_op.kind    = OP_NOP;
    q_op.bin     = BIN_AND;
    q_op.bit_val = 1'b0;
    q_op.nondet  = 1'b0;
    q_op.last    = in_tlast;
    unique case (func)
      FN_FALSE:  q_op.kind = OP_PUSH;
      FN_TRUE: begin
        q_op.kind    = OP_PUSH;
        q_op.bit_val = 1'b1;
      end
      FN_NONDET: begin
        q_op.kind   = OP_PUSH;
        q_op.nondet = 1'b1;
      end
      FN_NOT:    q_op.kind = OP_NOT;
      FN_AND: begin
        q_op.kind = OP_BIN;
        q_op.bin  = BIN_AND;
      end
      FN_OR: begin
        q_op.kind = OP_BIN;
        q_op.bin  = BIN_OR;
      end
      FN_XOR: begin
        q_op.kind = OP_BIN;
        q_op.bin  = BIN_XOR;
      end
      FN_EQ: begin
        q_op.kind = OP_BIN;
        q_op.bin  = BIN_EQ;
      end
      FN_NEQ: begin
        q_op.kind = OP_BIN;
        q_op.bin  = BIN_NEQ;
      end
      FN_VAR: begin
        q_op.kind    = OP_PUSH;
        q_op.bit_val = var_bit;
      end
      default: q_op.kind = OP_NOP;  // parenthesis and unused codes
    endcase
  end

endmodule

/* sv/pbse_fifo.sv */
module pbse_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pbse_pkg::op_t       wr_op,
  input  logic                pop,
  output pbse_pkg::op_t       head,
  output pbse_pkg::q_status_t q_st
);
  import pbse_pkg::*;

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] level_r, level_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign q_st.level = level_r;
  assign q_st.full  = level_r == QLVL_W'(QUEUE_DEPTH);
  assign q_st.empty = level_r == '0;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

/* sv/pbse_back.sv */
module pbse_back #(
  parameter int STACK_DEPTH = 16,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pbse_pkg::op_t       head,
  input  pbse_pkg::q_status_t q_st,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // value[0], status[2:1], zero pad
  output logic [CW-1:0]       stack_cnt
);
  import pbse_pkg::*;

  // The stack shifts: entry 0 is always the top, entry 1 the one below it.
  logic [STACK_DEPTH-1:0] stk_r, stk_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  status_t                err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_value_r, res_value;
  status_t                out_status_r;
  logic                   bin_res;

  // A result only needs the output register; other tokens never wait on it.
  assign pop = !q_st.empty && (!head.last || !out_valid_r || out_tready);

  always_comb begin
    unique case (head.bin)
      BIN_AND: bin_res = stk_r[0] & stk_r[1];
      BIN_OR:  bin_res = stk_r[0] | stk_r[1];
      BIN_XOR: bin_res = stk_r[0] ^ stk_r[1];
      BIN_EQ:  bin_res = stk_r[0] ~^ stk_r[1];
      default: bin_res = stk_r[0] ^ stk_r[1];
    endcase
  end

  always_comb begin
    stk_nxt   = stk_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    res_value = 1'b0;
    if (pop) begin
      unique case (head.kind)
        OP_PUSH: begin
          if (head.nondet && err_nxt == ST_OK) begin
            err_nxt = ST_NONDET;
          end
          if (cnt_r == CW'(STACK_DEPTH)) begin
            if (err_nxt == ST_OK) begin
              err_nxt = ST_OVER;
            end
          end else begin
            for (int i = 1; i < STACK_DEPTH; i++) begin
              stk_nxt[i] = stk_r[i-1];
            end
            stk_nxt[0] = head.bit_val;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
        OP_NOT: begin
          if (cnt_r == '0) begin
            if (err_nxt == ST_OK) begin
              err_nxt = ST_UNDER;
            end
          end else begin
            stk_nxt[0] = !stk_r[0];
          end
        end
        OP_BIN: begin
          if (cnt_r < CW'(2)) begin
            if (err_nxt == ST_OK) begin
              err_nxt = ST_UNDER;
            end
          end else begin
            for (int i = 1; i < STACK_DEPTH - 1; i++) begin
              stk_nxt[i] = stk_r[i+1];
            end
            stk_nxt[0] = bin_res;
            cnt_nxt    = cnt_r - 1'b1;
          end
        end
        default: ;
      endcase
      if (head.last) begin
        res_value = (cnt_nxt != '0) && stk_nxt[0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && head.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop && head.last) begin
        cnt_r <= '0;
        err_r <= ST_OK;
      end else begin
        cnt_r <= cnt_nxt;
        err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    stk_r <= stk_nxt;
    if (pop && head.last) begin
      out_value_r  <= res_value;
      out_status_r <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_value_r};
  assign stack_cnt  = cnt_r;

endmodule

/* sv/postfix_boolean_stack_evaluator.sv */
// Throughput: one token per cycle, sustained, with results taken promptly.
// A token marked last is written into the token queue on acceptance; once it is
// popped from the queue head, its result is registered and shown on out_tvalid.
// A waiting result stalls the next last token at the queue head; the two-entry
// queue then fills and in_tready drops. Earlier tokens keep flowing.
// Reset (rst_n, synchronous, active low) clears the variables, queue, count and status.
module postfix_boolean_stack_evaluator #(
  parameter int STACK_DEPTH = 16,
  parameter int SHARED_VARS = 16,
  parameter int LOCAL_VARS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // var_bank[1:0], var_index[5:2], zero pad
  input  logic [3:0]  in_tuser,     // func[3:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // value[0], status[2:1], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pbse_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  vars_t         vars_r;
  q_status_t     q_st;
  logic          q_push;
  logic          q_pop;
  op_t           q_op;
  op_t           head;
  logic [CW-1:0] stack_cnt;
  logic          cfg_wr;
  reg_t          cfg_reg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_reg    = reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vars_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_SHARED_NOW:  vars_r.shared_now  <= cfg_pwdata[VAR_BITS-1:0];
        REG_LOCAL_NOW:   vars_r.local_now   <= cfg_pwdata[VAR_BITS-1:0];
        REG_SHARED_NEXT: vars_r.shared_next <= cfg_pwdata[VAR_BITS-1:0];
        default:         vars_r.local_next  <= cfg_pwdata[VAR_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_SHARED_NOW:  cfg_prdata = {16'd0, vars_r.shared_now};
      REG_LOCAL_NOW:   cfg_prdata = {16'd0, vars_r.local_now};
      REG_SHARED_NEXT: cfg_prdata = {16'd0, vars_r.shared_next};
      default:         cfg_prdata = {16'd0, vars_r.local_next};
    endcase
  end

  pbse_front #(
    .SHARED_VARS (SHARED_VARS),
    .LOCAL_VARS  (LOCAL_VARS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .vars      (vars_r),
    .q_st      (q_st),
    .q_push    (q_push),
    .q_op      (q_op)
  );

  pbse_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr_op (q_op),
    .pop   (q_pop),
    .head  (head),
    .q_st  (q_st)
  );

  pbse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_st       (q_st),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stack_cnt  (stack_cnt)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.level <= QLVL_W'(QUEUE_DEPTH))
    else $error("token queue level exceeds its depth");

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |=> q_st.level == $past(q_st.level) + 1'b1)
    else $error("token queue lost a written item");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_cnt <= CW'(STACK_DEPTH))
    else $error("stack count exceeds the stack depth");

  a_stack_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && head.last |=> stack_cnt == '0 && out_tvalid)
    else $error("last token did not clear the stack and raise a result");

endmodule

/* verif/postfix_boolean_stack_evaluator_test.sv */
`timescale 1ns / 100ps

module postfix_boolean_stack_evaluator_test;
  import pbse_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1850;
  localparam int SEGMENTS    = 6;
  localparam logic [3:0] FN_SPARE = 4'd15;

  typedef struct packed {
    logic    value;
    status_t status;
  } verdict_t;

  typedef struct {
    logic [3:0] fn;
    logic [1:0] bank;
    logic [3:0] idx;
  } token_t;

  typedef struct {
    token_t   tok;
    logic     lst;
    int       reps;
    logic     typed;
    verdict_t res;
  } row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;  // var_bank[1:0], var_index[5:2], zero pad
  logic [3:0]  in_tuser    = 4'h0;   // func[3:0]
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;            // value[0], status[2:1], zero pad
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = 4'h0;
  logic [31:0] cfg_pwdata  = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow of the block: variable banks, operand stack and sticky status.
  logic [15:0]      var_regs [4];
  logic [STACK_DEPTH-1:0] opstack = '0;
  int               op_depth = 0;
  status_t          sticky_status = ST_OK;
  verdict_t         pending_results [$];
  verdict_t         oldest;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int items_sent   = 0;
  int err_count    = 0;
  int cycle_count  = 0;

  postfix_boolean_stack_evaluator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic void raise_status(input status_t code);
    if (sticky_status == ST_OK) sticky_status = code;
  endfunction

  function automatic void push_operand(input logic v);
    if (op_depth >= STACK_DEPTH) begin
      raise_status(ST_OVER);
    end else begin
      opstack[op_depth] = v;
      op_depth++;
    end
  endfunction

  task automatic eval_token(input token_t t, input logic lst, output logic has_res,
                            output verdict_t res);
    logic a;
    logic b;
    logic r;
    has_res = 1'b0;
    res = '0;
    case (t.fn)
      FN_FALSE: push_operand(1'b0);
      FN_TRUE: push_operand(1'b1);
      FN_NONDET: begin
        raise_status(ST_NONDET);
        push_operand(1'b0);
      end
      FN_NOT: begin
        if (op_depth < 1) raise_status(ST_UNDER);
        else opstack[op_depth-1] = ~opstack[op_depth-1];
      end
      FN_AND, FN_OR, FN_XOR, FN_EQ, FN_NEQ: begin
        if (op_depth < 2) begin
          raise_status(ST_UNDER);
        end else begin
          a = opstack[op_depth-1];
          b = opstack[op_depth-2];
          case (t.fn)
            FN_AND: r = a & b;
            FN_OR: r = a | b;
            FN_XOR: r = a ^ b;
            FN_EQ: r = (a == b);
            default: r = (a != b);
          endcase
          opstack[op_depth-1] = 1'b0;
          opstack[op_depth-2] = r;
          op_depth--;
        end
      end
      FN_VAR: push_operand(var_regs[t.bank][t.idx]);
      default: ;
    endcase
    if (lst) begin
      has_res = 1'b1;
      res.value = (op_depth > 0) ? opstack[op_depth-1] : 1'b0;
      res.status = sticky_status;
      opstack = '0;
      op_depth = 0;
      sticky_status = ST_OK;
    end
  endtask

  task automatic write_reg(input reg_t r, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    var_regs[r] = v[15:0];
  endtask

  task automatic check_reg(input reg_t r, input logic [15:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {r, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== want)
      report_mismatch($sformatf("register %s reads %h, want %h", r.name(),
                                cfg_prdata[15:0], want));
  endtask

  // Presents one item, waits for it to be taken and records what it should produce.
  task automatic send_token(input token_t t, input logic lst, input logic typed,
                            input verdict_t typed_res);
    logic     has_res;
    verdict_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= t.fn;
    in_tdata  <= {2'b00, t.idx, t.bank};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    eval_token(t, lst, has_res, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Items without a result may still be inside the block.
    repeat (4) @(posedge clk);
  endtask

  function automatic token_t rand_token(input logic [3:0] fn);
    token_t t;
    t.fn   = fn;
    t.bank = 2'($urandom_range(3));
    t.idx  = 4'($urandom_range(15));
    return t;
  endfunction

  function automatic token_t rand_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return rand_token(FN_VAR);
    if (pick < 70) return rand_token(FN_TRUE);
    if (pick < 96) return rand_token(FN_FALSE);
    return rand_token(FN_NONDET);
  endfunction

  function automatic row_t mk_row(input logic [3:0] fn, input bank_t bank,
                                  input logic [3:0] idx, input int lst, input int reps,
                                  input int typed, input int val, input status_t st);
    row_t r;
    r.tok.fn     = fn;
    r.tok.bank   = bank;
    r.tok.idx    = idx;
    r.lst        = (lst != 0);
    r.reps       = reps;
    r.typed      = (typed != 0);
    r.res.value  = (val != 0);
    r.res.status = st;
    return r;
  endfunction

  // Mostly well-formed expressions; a share of them deep enough to overflow,
  // and a share of raw noise with the last flag set at random.
  task automatic send_expression();
    token_t toks [$];
    int     mode;
    int     pushes;
    int     d;
    mode = $urandom_range(99);
    if (mode < 12) begin
      repeat ($urandom_range(1, 8))
        send_token(rand_token(4'($urandom_range(15))), $urandom_range(7) == 0, 1'b0, '0);
      return;
    end
    pushes = (mode < 22) ? $urandom_range(15, 18) : $urandom_range(1, 10);
    d = 0;
    while (pushes > 0 || d > 1) begin
      if (d >= 2 && (pushes == 0 || $urandom_range(2) == 0)) begin
        toks.push_back(rand_token(4'(FN_AND + $urandom_range(4))));
        d--;
      end else begin
        toks.push_back(rand_operand());
        pushes--;
        if (d < STACK_DEPTH) d++;
      end
      if ($urandom_range(9) == 0)
        toks.push_back(rand_token(($urandom_range(1) == 1) ? FN_NOT : FN_PAREN));
    end
    foreach (toks[k]) send_token(toks[k], k == toks.size() - 1, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result item %h", out_tdata));
      end else begin
        oldest = pending_results[0];
        pending_results.delete(0);
        if (out_tdata[0] !== oldest.value)
          report_mismatch($sformatf("value %b, want %b", out_tdata[0], oldest.value));
        if (out_tdata[2:1] !== oldest.status)
          report_mismatch($sformatf("status %0d, want %s", out_tdata[2:1],
                                    oldest.status.name()));
      end
    end
  end

  initial begin
    row_t        rows [$];
    int          target;
    logic [31:0] v;
    for (int r = 0; r < 4; r++) var_regs[r] = 16'h0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < 4; r++) check_reg(reg_t'(r), 16'h0000);
    in_idle_pct  = 10;
    out_idle_pct = 74;
    write_reg(REG_SHARED_NOW,  32'h0000_FFFF);
    write_reg(REG_LOCAL_NOW,   32'hABCD_0000);
    write_reg(REG_SHARED_NEXT, 32'h0000_8001);
    write_reg(REG_LOCAL_NEXT,  32'h0000_5555);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;

    rows.push_back(mk_row(FN_PAREN,  BANK_SHARED_NOW,  4'd0,  1, 1, 1, 0, ST_OK));
    rows.push_back(mk_row(FN_TRUE,   BANK_SHARED_NOW,  4'd0,  1, 1, 1, 1, ST_OK));
    rows.push_back(mk_row(FN_FALSE,  BANK_SHARED_NOW,  4'd0,  1, 1, 1, 0, ST_OK));
    rows.push_back(mk_row(FN_NONDET, BANK_SHARED_NOW,  4'd0,  1, 1, 1, 0, ST_NONDET));
    rows.push_back(mk_row(FN_NOT,    BANK_SHARED_NOW,  4'd0,  1, 1, 1, 0, ST_UNDER));
    rows.push_back(mk_row(FN_VAR,    BANK_SHARED_NOW,  4'd15, 1, 1, 1, 1, ST_OK));
    rows.push_back(mk_row(FN_VAR,    BANK_LOCAL_NOW,   4'd15, 1, 1, 1, 0, ST_OK));
    rows.push_back(mk_row(FN_VAR,    BANK_SHARED_NEXT, 4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_VAR,    BANK_LOCAL_NEXT,  4'd1,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_XOR,    BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_VAR,    BANK_SHARED_NEXT, 4'd15, 0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_EQ,     BANK_SHARED_NOW,  4'd0,  1, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_TRUE,   BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_FALSE,  BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_AND,    BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_TRUE,   BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_OR,     BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_FALSE,  BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_NEQ,    BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_NOT,    BANK_SHARED_NOW,  4'd0,  1, 1, 0, 0, ST_OK));
    // A binary operator on a single operand leaves the stack as it was.
    rows.push_back(mk_row(FN_TRUE,   BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_AND,    BANK_SHARED_NOW,  4'd0,  1, 1, 1, 1, ST_UNDER));
    // The first error is kept; the later nondeterministic constant is not recorded.
    rows.push_back(mk_row(FN_NOT,    BANK_SHARED_NOW,  4'd0,  0, 1, 0, 0, ST_OK));
    rows.push_back(mk_row(FN_NONDET, BANK_SHARED_NOW,  4'd0,  1, 1, 1, 0, ST_UNDER));
    rows.push_back(mk_row(FN_TRUE,   BANK_LOCAL_NEXT,  4'd15, 1, 17, 1, 1, ST_OVER));
    rows.push_back(mk_row(FN_SPARE,  BANK_LOCAL_NEXT,  4'd15, 1, 1, 1, 0, ST_OK));

    foreach (rows[i])
      for (int n = 0; n < rows[i].reps; n++)
        send_token(rows[i].tok, rows[i].lst && n == rows[i].reps - 1, rows[i].typed,
                   rows[i].res);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg / 2)
        0: begin in_idle_pct = 10; out_idle_pct = 74; end
        1: begin in_idle_pct = 74; out_idle_pct = 10; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int r = 0; r < 4; r++) begin
        v = (seg == 0) ? 32'hFFFF_FFFF : (seg == 1) ? 32'h0000_0000 : $urandom;
        write_reg(reg_t'(r), v);
        check_reg(reg_t'(r), v[15:0]);
      end
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      target = items_sent + ITEM_TARGET / SEGMENTS;
      while (items_sent < target) send_expression();
    end

    drain();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/pbse_pkg.sv
sv/pbse_front.sv
sv/pbse_fifo.sv
sv/pbse_back.sv
sv/postfix_boolean_stack_evaluator.sv
verif/postfix_boolean_stack_evaluator_test.sv
